FILE: sv/dpjs_pkg.sv
// Shared widths, types and codes for the deadline profit job selector.
`default_nettype none
package dpjs_pkg;

  localparam int DEADLINE_W = 32;
  localparam int PROFIT_W   = 31;
  localparam int TOTAL_W    = 41;
  localparam int COUNT_W    = 11;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_EMIT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_DECIDE,
    DP_UP_CHK,
    DP_UP_CMP,
    DP_DN_RD,
    DP_DN_CMP,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic push_ok;
    logic rep_ok;
    logic pos_zero;
    logic up_move;
    logic dn_move;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: sv/dpjs_datapath.sv
// Heap memory, sift engine, running total and result registers.
`default_nettype none
module dpjs_datapath import dpjs_pkg::*; #(
  parameter int HEAP_DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_op_t                op,
  output dp_status_t                 status,
  input  wire logic                  clear_before,
  input  wire logic [DEADLINE_W-1:0] job_deadline,
  input  wire logic [PROFIT_W-1:0]   job_profit,
  output logic [TOTAL_W-1:0]         total_profit,
  output logic [COUNT_W-1:0]         kept_count,
  output logic                       job_taken,
  output logic                       heap_overflow
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int IW = AW + 2;
  localparam int TW = PROFIT_W + CW;
  localparam int SW = (TW > TOTAL_W) ? TW : TOTAL_W;
  localparam int KW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [PROFIT_W-1:0]   mem [HEAP_DEPTH];
  logic [PROFIT_W-1:0]   rd_a;
  logic [PROFIT_W-1:0]   rd_b;

  logic [DEADLINE_W-1:0] deadline;
  logic [PROFIT_W-1:0]   val;
  logic [PROFIT_W-1:0]   min_val;
  logic [CW-1:0]         count;
  logic [TW-1:0]         total;
  logic [AW-1:0]         pos;
  logic                  taken;
  logic                  ovf;

  logic                  fresh;
  logic                  at_cap;
  logic                  ovf_c;
  logic                  try_rep;
  logic [AW-1:0]         parent;
  logic [IW-1:0]         l_idx;
  logic [IW-1:0]         r_idx;
  logic [IW-1:0]         count_i;
  logic                  l_less;
  logic                  r_less;
  logic [PROFIT_W-1:0]   pick_val;
  logic [PROFIT_W-1:0]   best_val;
  logic [AW-1:0]         best_pos;
  logic [AW-1:0]         raddr_a;
  logic [AW-1:0]         raddr_b;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [PROFIT_W-1:0]   wdata;
  logic [SW-1:0]         total_ext;
  logic [KW-1:0]         count_ext;

  always_comb begin
    fresh    = deadline > DEADLINE_W'(count);
    at_cap   = count == CW'(HEAP_DEPTH);
    ovf_c    = fresh && at_cap;
    try_rep  = ovf_c || (!fresh && count != '0);
    parent   = (pos - AW'(1)) >> 1;
    l_idx    = IW'({pos, 1'b1});
    r_idx    = l_idx + IW'(1);
    count_i  = IW'(count);
    l_less   = (l_idx < count_i) && (rd_a < val);
    pick_val = l_less ? rd_a : val;
    r_less   = (r_idx < count_i) && (rd_b < pick_val);
    if (r_less) begin
      best_val = rd_b;
      best_pos = r_idx[AW-1:0];
    end else begin
      best_val = rd_a;
      best_pos = l_idx[AW-1:0];
    end

    status.push_ok  = fresh && !at_cap;
    status.rep_ok   = try_rep && count != '0 && min_val < val;
    status.pos_zero = pos == '0;
    status.up_move  = rd_a > val;
    status.dn_move  = l_less || r_less;

    raddr_a = (op == DP_UP_CHK) ? parent : l_idx[AW-1:0];
    raddr_b = r_idx[AW-1:0];

    we    = 1'b0;
    waddr = pos;
    wdata = val;
    unique case (op)
      DP_UP_CHK: we = status.pos_zero;
      DP_UP_CMP: begin
        we    = 1'b1;
        wdata = status.up_move ? rd_a : val;
      end
      DP_DN_CMP: begin
        we    = 1'b1;
        wdata = status.dn_move ? best_val : val;
      end
      default: we = 1'b0;
    endcase

    total_ext = SW'(total);
    count_ext = KW'(count);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (we && waddr == '0) begin
      min_val <= wdata;
    end
    unique case (op)
      DP_LOAD: begin
        deadline <= job_deadline;
        val      <= job_profit;
      end
      DP_DECIDE: begin
        taken <= status.push_ok || status.rep_ok;
        ovf   <= ovf_c;
        if (status.push_ok) begin
          pos <= count[AW-1:0];
        end else begin
          pos <= '0;
        end
      end
      DP_UP_CMP: begin
        if (status.up_move) begin
          pos <= parent;
        end
      end
      DP_DN_CMP: begin
        if (status.dn_move) begin
          pos <= best_pos;
        end
      end
      DP_EMIT: begin
        total_profit  <= (total_ext > SW'(TOTAL_MAX)) ? TOTAL_MAX : total_ext[TOTAL_W-1:0];
        kept_count    <= (count_ext > KW'(COUNT_MAX)) ? COUNT_MAX : count_ext[COUNT_W-1:0];
        job_taken     <= taken;
        heap_overflow <= ovf;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (op == DP_LOAD && clear_before) begin
      count <= '0;
      total <= '0;
    end else if (op == DP_DECIDE) begin
      if (status.push_ok) begin
        count <= count + CW'(1);
        total <= total + TW'(val);
      end else if (status.rep_ok) begin
        total <= total + TW'(val) - TW'(min_val);
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/dpjs_ctrl.sv
// Sequencer: handshakes and the step order of push and replace sifts.
`default_nettype none
module dpjs_ctrl import dpjs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_op_t          op
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    op             = DP_NOP;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = DP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        op = DP_DECIDE;
        if (status.push_ok) begin
          state_next = S_UP_CHK;
        end else if (status.rep_ok) begin
          state_next = S_DN_RD;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_UP_CHK: begin
        op         = DP_UP_CHK;
        state_next = status.pos_zero ? S_EMIT : S_UP_CMP;
      end
      S_UP_CMP: begin
        op         = DP_UP_CMP;
        state_next = status.up_move ? S_UP_CHK : S_EMIT;
      end
      S_DN_RD: begin
        op         = DP_DN_RD;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        op         = DP_DN_CMP;
        state_next = status.dn_move ? S_DN_RD : S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          op             = DP_EMIT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/deadline_profit_job_selector.sv
// Top level of the deadline profit job selector.
// The user must send jobs in non-decreasing deadline order; the block itself does
// not enforce it. One job per input transfer; each produces one result transfer
// with the running total, the kept count and the taken and overflow flags. A
// rejected job passes load, decide and emit; a pushed job adds an upward sift and
// a replacing job a downward sift from the root, one heap level per loop step.
// Each step over the single-write heap memory is a registered read followed by
// one write. A new job is taken while the previous result still waits in the
// output register.
`default_nettype none
module deadline_profit_job_selector import dpjs_pkg::*; #(
  parameter int HEAP_DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  clear_before,
  input  wire logic [DEADLINE_W-1:0] job_deadline,
  input  wire logic [PROFIT_W-1:0]   job_profit,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [TOTAL_W-1:0]         total_profit,
  output logic [COUNT_W-1:0]         kept_count,
  output logic                       job_taken,
  output logic                       heap_overflow
);

  dp_op_t     op;
  dp_status_t status;

  dpjs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  dpjs_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .status        (status),
    .clear_before  (clear_before),
    .job_deadline  (job_deadline),
    .job_profit    (job_profit),
    .total_profit  (total_profit),
    .kept_count    (kept_count),
    .job_taken     (job_taken),
    .heap_overflow (heap_overflow)
  );

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Testbench for deadline_profit_job_selector: directed, full-heap, stall and random job sets.
`default_nettype none
module testbench;
  import dpjs_pkg::*;

  localparam int          HEAP_DEPTH  = 1024;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam logic [PROFIT_W-1:0]   PROFIT_MAX   = '1;
  localparam logic [DEADLINE_W-1:0] DEADLINE_MAX = '1;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
    logic               taken;
    logic               overflow;
  } job_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  clear_before = 1'b0;
  logic [DEADLINE_W-1:0] job_deadline = '0;
  logic [PROFIT_W-1:0]   job_profit = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [TOTAL_W-1:0]    total_profit;
  logic [COUNT_W-1:0]    kept_count;
  logic                  job_taken;
  logic                  heap_overflow;

  deadline_profit_job_selector #(.HEAP_DEPTH(HEAP_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .clear_before(clear_before), .job_deadline(job_deadline), .job_profit(job_profit),
    .out_valid(out_valid), .out_ready(out_ready),
    .total_profit(total_profit), .kept_count(kept_count),
    .job_taken(job_taken), .heap_overflow(heap_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [PROFIT_W-1:0] kept_profits [HEAP_DEPTH];
  int unsigned         kept_jobs = 0;
  longint unsigned     profit_sum = 0;

  job_result_t queued_job_results [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  function automatic job_result_t select_job(input logic clr, input logic [DEADLINE_W-1:0] dl,
                                             input logic [PROFIT_W-1:0] pr);
    int unsigned         pos;
    int unsigned         best;
    int unsigned         child;
    logic [PROFIT_W-1:0] tmp;
    logic                try_swap;
    logic                settled;
    job_result_t         r;
    r = '0;
    try_swap = 1'b0;
    if (clr) begin
      kept_jobs = 0;
      profit_sum = 0;
    end
    if (dl > kept_jobs) begin
      if (kept_jobs < HEAP_DEPTH) begin
        pos = kept_jobs;
        kept_profits[pos] = pr;
        while (pos > 0 && kept_profits[(pos - 1) / 2] > kept_profits[pos]) begin
          tmp = kept_profits[(pos - 1) / 2];
          kept_profits[(pos - 1) / 2] = kept_profits[pos];
          kept_profits[pos] = tmp;
          pos = (pos - 1) / 2;
        end
        kept_jobs++;
        profit_sum += pr;
        r.taken = 1'b1;
      end else begin
        r.overflow = 1'b1;
        try_swap = 1'b1;
      end
    end else if (kept_jobs > 0) begin
      try_swap = 1'b1;
    end
    if (try_swap && kept_jobs > 0 && kept_profits[0] < pr) begin
      profit_sum += longint'(pr) - longint'(kept_profits[0]);
      kept_profits[0] = pr;
      pos = 0;
      settled = 1'b0;
      while (!settled) begin
        child = 2 * pos + 1;
        best = pos;
        if (child < kept_jobs && kept_profits[child] < kept_profits[best]) best = child;
        if (child + 1 < kept_jobs && kept_profits[child + 1] < kept_profits[best])
          best = child + 1;
        if (best == pos) begin
          settled = 1'b1;
        end else begin
          tmp = kept_profits[best];
          kept_profits[best] = kept_profits[pos];
          kept_profits[pos] = tmp;
          pos = best;
        end
      end
      r.taken = 1'b1;
    end
    r.total = (profit_sum > TOTAL_MAX) ? TOTAL_MAX : profit_sum[TOTAL_W-1:0];
    r.count = (kept_jobs > COUNT_MAX) ? COUNT_MAX : kept_jobs[COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_job(input logic clr, input logic [DEADLINE_W-1:0] dl,
                          input logic [PROFIT_W-1:0] pr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    clear_before <= clr;
    job_deadline <= dl;
    job_profit   <= pr;
    queued_job_results.push_back(select_job(clr, dl, pr));
    do @(posedge clk); while (!in_ready);
  endtask

  // result check and receiver stalls
  always @(posedge clk) begin : check_results
    job_result_t want;
    job_result_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {total_profit, kept_count, job_taken, heap_overflow};
        if (queued_job_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result total=%0d count=%0d taken=%0b overflow=%0b",
                   $time, got.total, got.count, got.taken, got.overflow);
        end else begin
          want = queued_job_results.pop_front();
          if (got !== want) begin
            error_count++;
            $display("%0t: mismatch expected total=%0d count=%0d taken=%0b overflow=%0b",
                     $time, want.total, want.count, want.taken, want.overflow);
            $display("%0t:          actual   total=%0d count=%0d taken=%0b overflow=%0b",
                     $time, got.total, got.count, got.taken, got.overflow);
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_directed();
    send_job(1'b1, '0, PROFIT_MAX);                  // refused with empty heap
    send_job(1'b0, 32'd1, '0);                       // push zero profit
    send_job(1'b0, 32'd1, PROFIT_MAX);               // replaces the minimum
    send_job(1'b0, 32'd1, PROFIT_MAX);               // equal profit, no replace
    send_job(1'b0, 32'd2, 31'd1);
    send_job(1'b0, 32'h5555_5555, 31'h2AAA_AAAA);
    send_job(1'b0, 32'hAAAA_AAAA, 31'h5555_5555);
    send_job(1'b0, DEADLINE_MAX, 31'd7);
    send_job(1'b0, 32'd1, 31'd3);                    // out of order, beats min
    send_job(1'b0, 32'd0, 31'd3);                    // out of order, equal to min
    send_job(1'b0, 32'd0, 31'd0);
    send_job(1'b1, 32'd0, 31'd5);                    // clear then refused
    send_job(1'b0, 32'd0, PROFIT_MAX);
    send_job(1'b1, 32'd1, 31'd9);                    // clear with nonempty result
    send_job(1'b0, 32'd1, 31'd9);
    send_job(1'b0, 32'd1, 31'd10);
    send_job(1'b1, DEADLINE_MAX, PROFIT_MAX);
    send_job(1'b0, DEADLINE_MAX, PROFIT_MAX);
  endtask

  task automatic test_heap_full();
    logic [PROFIT_W-1:0] pr;
    for (int i = 0; i < HEAP_DEPTH; i++) begin
      pr = ($urandom_range(3) == 0) ? PROFIT_MAX : PROFIT_W'($urandom);
      send_job(i == 0, DEADLINE_W'(i + 1), pr);
    end
    send_job(1'b0, DEADLINE_MAX, kept_profits[0]);   // full, equal to min
    send_job(1'b0, DEADLINE_MAX, '0);                // full, loses
    send_job(1'b0, 32'd1025, PROFIT_MAX);            // full, replaces
    send_job(1'b0, 32'd1024, PROFIT_MAX);            // not above count: plain replace path
    for (int i = 0; i < 8; i++) send_job(1'b0, DEADLINE_MAX, PROFIT_W'($urandom));
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_req <= 1'b1;
    send_job(1'b1, 32'd3, 31'd100);
    for (int i = 0; i < 40; i++)
      send_job(1'b0, DEADLINE_W'(3 + i / 2), PROFIT_W'($urandom_range(1000)));
  endtask

  task automatic test_random(input int n_jobs, input int send_pct, input int recv_pct);
    int                    sent;
    int                    set_len;
    int                    pick;
    logic [DEADLINE_W-1:0] dl;
    logic [DEADLINE_W-1:0] dl_now;
    logic [PROFIT_W-1:0]   pr;
    logic                  clr;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_jobs) begin
      set_len = ($urandom_range(99) < 10) ? $urandom_range(80, 40) : $urandom_range(20, 1);
      dl = $urandom_range(3);
      for (int j = 0; j < set_len; j++) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          dl_now = $urandom;
        end else if (pick < 10) begin
          dl_now = $urandom_range(dl);
        end else begin
          dl = dl + $urandom_range(2);
          dl_now = dl;
        end
        case ($urandom_range(9))
          0:       pr = '0;
          1:       pr = PROFIT_MAX;
          2, 3, 4: pr = PROFIT_W'($urandom_range(15));
          default: pr = PROFIT_W'($urandom);
        endcase
        clr = (j == 0) || ($urandom_range(99) < 3);
        send_job(clr, dl_now, pr);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 54;
    test_directed();
    test_heap_full();
    test_backpressure();
    test_random(15, 22, 54);
    test_random(15, 54, 22);
    test_random(15, 0, 0);
    in_valid <= 1'b0;
    while (queued_job_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: deadline_profit_job_selector.f
sv/dpjs_pkg.sv
sv/dpjs_datapath.sv
sv/dpjs_ctrl.sv
sv/deadline_profit_job_selector.sv
sim/testbench.sv
